// ===== hw/rtl/erp_pkg.sv =====
// ----------------------------------------------------------------------------
// erp_pkg
// Shared constants for the equirectangular pixel to unit sphere mapper.
// ----------------------------------------------------------------------------
package erp_pkg;

  localparam int unsigned MaxDimDefault = 16384;
  localparam int unsigned OutFracDefault = 15;

  localparam int unsigned DimW = 15;
  localparam int unsigned ColW = 14;
  localparam int unsigned OutW = 16;
  localparam int unsigned AngW = 16;

  localparam int unsigned DivSteps = 16;
  localparam int unsigned DivW = 33;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned CordicW = 33;
  localparam logic signed [CordicW-1:0] CordicInit = 33'sd652032874;

  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWidth  = 1'b0,
    CfgHeight = 1'b1
  } cfg_idx_e;

  // atan(2^-i) in 2^-32 turn units
  localparam logic signed [CordicW-1:0] AtanTurn32 [CordicSteps] = '{
    33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756,
    33'sd42667331, 33'sd21354465, 33'sd10679838, 33'sd5340245,
    33'sd2670163, 33'sd1335087, 33'sd667544, 33'sd333772,
    33'sd166886, 33'sd83443, 33'sd41722, 33'sd20861
  };

endpackage

// ===== hw/rtl/erp_cordic.sv =====
// ----------------------------------------------------------------------------
// erp_cordic
// Pipelined rotation CORDIC giving Q2.30 cosine and sine of a turn angle.
// ----------------------------------------------------------------------------
module erp_cordic import erp_pkg::*; (
  input  logic                       clk_i,
  input  logic [AngW-1:0]            angle_i,
  output logic signed [31:0]         cos_o,
  output logic signed [31:0]         sin_o
);

  logic signed [CordicW-1:0] x_q [CordicSteps+1];
  logic signed [CordicW-1:0] y_q [CordicSteps+1];
  logic signed [CordicW-1:0] z_q [CordicSteps+1];
  logic [1:0]                quad_q [CordicSteps+1];

  logic [AngW-1:0] ang_rnd;
  logic [1:0]      quad_d;
  logic [AngW-1:0] res_d;

  assign ang_rnd = angle_i + AngW'(16'h2000);
  assign quad_d  = ang_rnd[AngW-1:AngW-2];
  assign res_d   = angle_i - {quad_d, 14'b0};

  // fold into one quadrant
  always_ff @(posedge clk_i) begin
    x_q[0]    <= CordicInit;
    y_q[0]    <= '0;
    z_q[0]    <= {res_d[AngW-1], res_d, 16'b0};
    quad_q[0] <= quad_d;
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (!z_q[i][CordicW-1]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - AtanTurn32[i];
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + AtanTurn32[i];
      end
      quad_q[i+1] <= quad_q[i];
    end
  end

  logic signed [CordicW-1:0] xf, yf;
  assign xf = x_q[CordicSteps];
  assign yf = y_q[CordicSteps];

  always_ff @(posedge clk_i) begin
    unique case (quad_q[CordicSteps])
      2'd0: begin
        cos_o <= 32'(xf);
        sin_o <= 32'(yf);
      end
      2'd1: begin
        cos_o <= 32'(-yf);
        sin_o <= 32'(xf);
      end
      2'd2: begin
        cos_o <= 32'(-xf);
        sin_o <= 32'(-yf);
      end
      default: begin
        cos_o <= 32'(yf);
        sin_o <= 32'(-xf);
      end
    endcase
  end

endmodule

// ===== hw/rtl/erp_pixel_to_sphere.sv =====
// ----------------------------------------------------------------------------
// erp_pixel_to_sphere
// Maps an equirectangular pixel to a Q1.15 point on the unit sphere.
// Result path: input register, divider, CORDIC, multiply and output registers.
// Throughput: one pixel per cycle; busy stays low, set by a fully pipelined
// 16-stage divider, two 18-stage CORDIC units and one multiply stage.
// Reset clears the valid line and loads width 4096, height 2048.
// The receiver cannot stall; results leave on the strobe alone.
// ----------------------------------------------------------------------------
module erp_pixel_to_sphere import erp_pkg::*; #(
  parameter int unsigned MAX_DIMENSION        = MaxDimDefault,
  parameter int unsigned OUTPUT_FRACTION_BITS = OutFracDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [ColW-1:0]        pixel_column_i,
  input  logic [ColW-1:0]        pixel_row_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxW-1:0]     cfg_index_i,
  input  logic [DimW-1:0]        cfg_data_i,
  output logic                   out_valid_o,
  output logic signed [OutW-1:0] sphere_x_o,
  output logic signed [OutW-1:0] sphere_y_o,
  output logic signed [OutW-1:0] sphere_z_o,
  output logic                   range_error_o
);

  localparam int unsigned CordicLat = CordicSteps + 2;
  localparam int unsigned Latency = 1 + DivSteps + CordicLat + 2;
  localparam int unsigned ShXZ = 60 - OUTPUT_FRACTION_BITS;
  localparam int unsigned ShY = 30 - OUTPUT_FRACTION_BITS;
  localparam logic signed [63:0] RndXZ = 64'sd1 <<< (ShXZ - 1);
  localparam logic signed [63:0] RndY = (64'sd1 <<< ShY) >>> 1;
  localparam logic signed [63:0] Lim = (OUTPUT_FRACTION_BITS >= 15) ? 64'sd32767 :
                                       (64'sd1 <<< OUTPUT_FRACTION_BITS) - 64'sd1;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  // configuration
  logic [DimW-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimW'(4096);
      height_q <= DimW'(2048);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgWidth:  width_q <= cfg_data_i;
        CfgHeight: height_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  logic [DimW-1:0] wcl, hcl;
  assign wcl = (17'(width_q) > 17'(MAX_DIMENSION)) ? DimW'(MAX_DIMENSION) : width_q;
  assign hcl = (17'(height_q) > 17'(MAX_DIMENSION)) ? DimW'(MAX_DIMENSION) : height_q;

  logic [15:0] div_a, div_e;
  assign div_a = {wcl, 1'b0};
  assign div_e = {hcl, 1'b0};

  // divider pipeline, one quotient bit per stage
  logic              v_q   [DivSteps+1];
  logic              err_q [DivSteps+1];
  logic [DivW-1:0]   ra_q  [DivSteps+1];
  logic [DivW-1:0]   re_q  [DivSteps+1];
  logic [15:0]       qa_q  [DivSteps+1];
  logic [15:0]       qe_q  [DivSteps+1];

  logic err_d;
  assign err_d = (wcl == '0) || (hcl == '0) ||
                 ({1'b0, pixel_column_i} >= wcl) || ({1'b0, pixel_row_i} >= hcl);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    err_q[0] <= err_d;
    ra_q[0]  <= DivW'({pixel_column_i, 1'b1, 16'b0}) + DivW'(wcl);
    re_q[0]  <= DivW'({pixel_row_i, 1'b1, 15'b0}) + DivW'(hcl);
    qa_q[0]  <= '0;
    qe_q[0]  <= '0;
  end

  for (genvar j = 1; j <= DivSteps; j++) begin : g_div
    localparam int unsigned K = DivSteps - j;
    logic [DivW-1:0] dsa, dse;
    logic            ga, ge;
    assign dsa = DivW'(div_a) << K;
    assign dse = DivW'(div_e) << K;
    assign ga  = ra_q[j-1] >= dsa;
    assign ge  = re_q[j-1] >= dse;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else begin
        v_q[j] <= v_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      err_q[j] <= err_q[j-1];
      ra_q[j]  <= ga ? ra_q[j-1] - dsa : ra_q[j-1];
      re_q[j]  <= ge ? re_q[j-1] - dse : re_q[j-1];
      qa_q[j]  <= {qa_q[j-1][14:0], ga};
      qe_q[j]  <= {qe_q[j-1][14:0], ge};
    end
  end

  logic [AngW-1:0] az, el;
  assign az = {~qa_q[DivSteps][15], qa_q[DivSteps][14:0]};
  assign el = AngW'(16384) - qe_q[DivSteps];

  logic signed [31:0] ce, se, ca, sa;

  erp_cordic u_cordic_el (
    .clk_i   (clk_i),
    .angle_i (el),
    .cos_o   (ce),
    .sin_o   (se)
  );

  erp_cordic u_cordic_az (
    .clk_i   (clk_i),
    .angle_i (az),
    .cos_o   (ca),
    .sin_o   (sa)
  );

  logic cv_q   [CordicLat];
  logic cerr_q [CordicLat];

  for (genvar j = 0; j < CordicLat; j++) begin : g_cdly
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[j] <= 1'b0;
      end else begin
        cv_q[j] <= (j == 0) ? v_q[DivSteps] : cv_q[(j == 0) ? 0 : j-1];
      end
    end
    always_ff @(posedge clk_i) begin
      cerr_q[j] <= (j == 0) ? err_q[DivSteps] : cerr_q[(j == 0) ? 0 : j-1];
    end
  end

  // products
  logic               mv_q, merr_q;
  logic signed [63:0] px_q, py_q, pz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else begin
      mv_q <= cv_q[CordicLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    merr_q <= cerr_q[CordicLat-1];
    px_q   <= ce * sa;
    pz_q   <= ce * ca;
    py_q   <= -64'(se);
  end

  function automatic logic signed [OutW-1:0] sat(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v;
    if (t > Lim) t = Lim;
    if (t < -Lim) t = -Lim;
    return OutW'(t);
  endfunction

  logic signed [63:0] rx, ry, rz;
  assign rx = (px_q + RndXZ) >>> ShXZ;
  assign rz = (pz_q + RndXZ) >>> ShXZ;
  assign ry = (py_q + RndY) >>> ShY;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else begin
      out_valid_o <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    range_error_o <= merr_q;
    sphere_x_o    <= merr_q ? '0 : sat(rx);
    sphere_y_o    <= merr_q ? '0 : sat(ry);
    sphere_z_o    <= merr_q ? '0 : sat(rz);
  end

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency out_valid_o)
    else $error("accepted pixel gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##Latency !out_valid_o)
    else $error("result without accepted pixel");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && range_error_o) |->
      (sphere_x_o == '0 && sphere_y_o == '0 && sphere_z_o == '0))
    else $error("out-of-frame beat carries nonzero coordinates");

  a_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sphere_x_o != 16'sh8000 && sphere_y_o != 16'sh8000 &&
                     sphere_z_o != 16'sh8000))
    else $error("coordinate beyond saturation limit");

endmodule

// ===== sim/erp_pixel_to_sphere_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// erp_pixel_to_sphere_tb
// Drives pixel coordinates through the equirectangular to unit sphere mapper
// under several frame sizes, predicts each sphere point with a fixed point
// CORDIC model and compares every strobed result against it in order.
// ----------------------------------------------------------------------------
module erp_pixel_to_sphere_tb;
  import erp_pkg::*;

  localparam int unsigned DrainCycles = 45;
  localparam int unsigned WatchdogLimit = 4000;

  typedef struct {
    logic signed [OutW-1:0] x;
    logic signed [OutW-1:0] y;
    logic signed [OutW-1:0] z;
    logic                   err;
  } sphere_pt_t;

  class sphere_scoreboard;
    sphere_pt_t     pending[$];
    logic [DimW-1:0] frame_w = 15'd4096;
    logic [DimW-1:0] frame_h = 15'd2048;
    int unsigned    errors = 0;

    function void set_dim(cfg_idx_e idx, logic [DimW-1:0] val);
      if (idx == CfgWidth) frame_w = val;
      else frame_h = val;
    endfunction

    function void cordic_sincos(logic [AngW-1:0] ang, output longint c, output longint s);
      int unsigned q;
      longint r, x, y, z, t;
      q = ((int'(ang) + 32'h2000) >> 14) & 3;
      r = longint'((int'(ang) - q * 32'h4000) & 32'hFFFF);
      if (r >= 32768) r -= 65536;
      x = 652032874;
      y = 0;
      z = r * 65536;
      for (int i = 0; i < CordicSteps; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z -= longint'(AtanTurn32[i]);
        end else begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z += longint'(AtanTurn32[i]);
        end
        x = t;
      end
      case (q)
        0: begin c = x; s = y; end
        1: begin c = -y; s = x; end
        2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function logic signed [OutW-1:0] round_sat(longint v, int shift);
      v = (v + (longint'(1) << (shift - 1))) >>> shift;
      if (v > 32767) v = 32767;
      if (v < -32767) v = -32767;
      return v[OutW-1:0];
    endfunction

    function void note_pixel(logic [ColW-1:0] col, logic [ColW-1:0] row);
      sphere_pt_t p;
      longint w, h, m, n, ce, se, ca, sa;
      logic [AngW-1:0] az, el;
      w = (frame_w > MaxDimDefault) ? MaxDimDefault : frame_w;
      h = (frame_h > MaxDimDefault) ? MaxDimDefault : frame_h;
      m = col;
      n = row;
      if (w == 0 || h == 0 || m >= w || n >= h) begin
        p = '{x: 0, y: 0, z: 0, err: 1'b1};
      end else begin
        az = AngW'(((((2 * m + 1) << 16) + w) / (2 * w)) + 32768);
        el = AngW'(16384 + 65536 - ((((2 * n + 1) << 15) + h) / (2 * h)));
        cordic_sincos(el, ce, se);
        cordic_sincos(az, ca, sa);
        p.x = round_sat(ce * sa, 45);
        p.y = round_sat(-se, 15);
        p.z = round_sat(ce * ca, 45);
        p.err = 1'b0;
      end
      pending.push_back(p);
    endfunction

    function void check_point(sphere_pt_t act);
      sphere_pt_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat x=%0d y=%0d z=%0d err=%0b",
                 $time, act.x, act.y, act.z, act.err);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (act.x !== e.x) begin
        $display("%0t: sphere_x expected %0d actual %0d", $time, e.x, act.x);
        errors++;
      end
      if (act.y !== e.y) begin
        $display("%0t: sphere_y expected %0d actual %0d", $time, e.y, act.y);
        errors++;
      end
      if (act.z !== e.z) begin
        $display("%0t: sphere_z expected %0d actual %0d", $time, e.z, act.z);
        errors++;
      end
      if (act.err !== e.err) begin
        $display("%0t: range_error expected %0b actual %0b", $time, e.err, act.err);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [ColW-1:0]        pixel_column_i = '0;
  logic [ColW-1:0]        pixel_row_i = '0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CfgIdxW-1:0]     cfg_index_i = CfgWidth;
  logic [DimW-1:0]        cfg_data_i = '0;
  logic                   out_valid_o;
  logic signed [OutW-1:0] sphere_x_o, sphere_y_o, sphere_z_o;
  logic                   range_error_o;

  sphere_scoreboard sb = new();
  bit               calm = 1'b0;
  int unsigned      quiet_cycles = 0;

  erp_pixel_to_sphere i_dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_pixel(pixel_column_i, pixel_row_i);
      if (out_valid_o)
        sb.check_point('{x: sphere_x_o, y: sphere_y_o, z: sphere_z_o, err: range_error_o});
      if ((start && !busy) || out_valid_o || (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_pixel(int unsigned col, int unsigned row);
    if (!calm) begin
      while ($urandom_range(99) < 38) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start <= 1'b1;
    pixel_column_i <= ColW'(col);
    pixel_row_i <= ColW'(row);
    do @(posedge clk_i); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_dim(cfg_idx_e idx, int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= DimW'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_dim(idx, DimW'(val));
  endtask

  task automatic set_frame(int unsigned w, int unsigned h);
    drain();
    write_dim(CfgWidth, w);
    write_dim(CfgHeight, h);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly in frame, the rest anywhere up to 16383, often past the edge
  task automatic random_pixels(int unsigned count);
    int unsigned w, h, col, row;
    w = (sb.frame_w > MaxDimDefault) ? MaxDimDefault : sb.frame_w;
    h = (sb.frame_h > MaxDimDefault) ? MaxDimDefault : sb.frame_h;
    for (int i = 0; i < count; i++) begin
      col = $urandom_range(16383);
      row = $urandom_range(16383);
      if ($urandom_range(9) < 8 && w > 0 && h > 0) begin
        col = $urandom_range(w - 1);
        row = $urandom_range(h - 1);
      end
      send_pixel(col, row);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset frame 4096 x 2048: corners, center, out of frame
    send_pixel(0, 0);
    send_pixel(4095, 2047);
    send_pixel(2048, 1024);
    send_pixel(0, 2047);
    send_pixel(4095, 0);
    send_pixel(4096, 0);
    send_pixel(0, 2048);
    send_pixel(16383, 16383);
    send_pixel(1023, 511);
    send_pixel(3071, 1535);
    // single pixel frame
    set_frame(1, 1);
    send_pixel(0, 0);
    send_pixel(1, 0);
    send_pixel(0, 1);
    // largest frame and oversize clamping
    set_frame(16384, 16384);
    send_pixel(16383, 16383);
    send_pixel(0, 8191);
    set_frame(32767, 20000);
    send_pixel(16383, 0);
    send_pixel(8192, 8192);
    // zero size
    set_frame(0, 100);
    send_pixel(0, 0);
    set_frame(100, 0);
    send_pixel(5, 0);

    set_frame(4096, 2048);
    random_pixels(110);
    set_frame(7, 3);
    random_pixels(70);
    calm = 1'b1;
    set_frame(16384, 16384);
    random_pixels(120);
    calm = 1'b0;
    set_frame($urandom_range(1, 16384), $urandom_range(1, 16384));
    random_pixels(110);
    set_frame(32767, 32767);
    random_pixels(60);
    set_frame($urandom_range(1, 300), $urandom_range(1, 300));
    random_pixels(60);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
